### hw/rtl/trial_division_prime_test_defines.svh
// ----------------------------------------------------------------------------
// Trial division prime test: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTH
`define TDPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TDPT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test: package
// Widths, state encoding and status types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_W = 32;
    localparam int DIV_W   = VALUE_W / 2 + 1;
    localparam int SQ_W    = VALUE_W + 1;
    localparam int CNT_W   = $clog2(VALUE_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } tdpt_state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } tdpt_div_sts_t;

endpackage

`default_nettype wire

### hw/rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test
// Tests a signed value for primality by trying divisors 2, 3, 4, ...
// while the divisor squared does not exceed the value.
//
//   channel   dir   tdata               tuser
//   s_        in    candidate [31:0]    -
//   m_        out   tested_value [31:0] is_prime [0]
//
// Values below 4 skip the divisor search. Each divisor tried goes through
// a bound check, a 32-step bit-serial remainder and a status step.
// Reset is synchronous, active low, and clears control state only.
// A stalled result holds in the output register; the next item is taken
// while it waits, and the search holds in its final state until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // [31:0] candidate
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [VALUE_W-1:0]  m_tdata,   // [31:0] tested_value
    output      logic [0:0]          m_tuser    // [0] is_prime
);

    tdpt_state_t         state_reg, state_next;
    logic [VALUE_W-1:0]  n_reg, n_next;
    logic [DIV_W-1:0]    d_reg, d_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic                prime_reg, prime_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_data_reg, m_data_next;
    logic                m_prime_reg, m_prime_next;

    logic                in_acc;
    logic                over_bound;
    logic                out_free;
    logic                div_start;
    tdpt_div_sts_t       div_sts;

    assign in_acc     = s_tvalid && s_tready;
    assign over_bound = (sq_reg > {1'b0, n_reg});
    assign out_free   = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tdata[VALUE_W-1] || s_tdata <= VALUE_W'(3)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                state_next = over_bound ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    state_next = div_sts.zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        div_start    = 1'b0;
        n_next       = n_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        prime_next   = prime_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_prime_next = m_prime_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    n_next     = s_tdata;
                    d_next     = DIV_W'(2);
                    sq_next    = SQ_W'(4);
                    prime_next = !s_tdata[VALUE_W-1] && s_tdata >= VALUE_W'(2);
                end
            end
            ST_CHECK: begin
                if (over_bound) begin
                    prime_next = 1'b1;
                end else begin
                    div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    if (div_sts.zero) begin
                        prime_next = 1'b0;
                    end else begin
                        sq_next = sq_reg + SQ_W'({d_reg, 1'b1});
                        d_next  = d_reg + DIV_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = n_reg;
                    m_prime_next = prime_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        prime_reg   <= prime_next;
        m_data_reg  <= m_data_next;
        m_prime_reg <= m_prime_next;
    end

    tdpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .sts      (div_sts)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_prime_reg;

    `TDPT_ASSERT_SAME(a_sq_tracks_div, aclk, aresetn, state_reg == ST_CHECK, sq_reg == SQ_W'(d_reg) * SQ_W'(d_reg))
    `TDPT_ASSERT_SAME(a_neg_not_prime, aclk, aresetn, m_tvalid && m_tdata[VALUE_W-1], !m_tuser[0])
    `TDPT_ASSERT_NEXT(a_done_posts, aclk, aresetn, state_reg == ST_DONE && out_free, m_tvalid && state_reg == ST_IDLE)
    `TDPT_ASSERT_SAME(a_div_only_in_div, aclk, aresetn, div_sts.done, state_reg == ST_DIV)

endmodule

`default_nettype wire

### hw/rtl/tdpt_div.sv
// ----------------------------------------------------------------------------
// Trial division prime test: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, reports a zero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_div
    import tdpt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [VALUE_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]    divisor,
    output tdpt_div_sts_t            sts
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  n_sh_reg, n_sh_next;
    logic [DIV_W-1:0]    r_reg, r_next;
    logic [DIV_W-1:0]    d_reg, d_next;
    logic [DIV_W:0]      trial;

    assign trial = {r_reg, n_sh_reg[VALUE_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_sh_next = n_sh_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_sh_next = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            n_sh_next = {n_sh_reg[VALUE_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                r_next = DIV_W'(trial - {1'b0, d_reg});
            end else begin
                r_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        n_sh_reg <= n_sh_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
    end

    assign sts.done = done_reg;
    assign sts.zero = (r_reg == '0);

endmodule

`default_nettype wire
